/* hw/rtl/dcf_pkg.sv */
// Shared types and constants for the delimited command framer.
`default_nettype none

package dcf_pkg;

   // Frame buffer geometry
   localparam int BUF_BYTES = 64;
   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int CNT_W     = 7;

   // Delimiter characters
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Framer phase
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_EMIT    = 2'd2,
      PH_DRAIN   = 2'd3
   } phase_type;

   // Buffer write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_port_type;

   // Drain request from the collector
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] length;
   } drain_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/dcf_buffer.sv */
// Frame byte store: one write port, one registered read port.
`default_nettype none

module dcf_buffer (
   input  wire logic                       clock,
   input  wire dcf_pkg::wr_port_type       wr,
   input  wire logic                       rd_en,
   input  wire logic [dcf_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [dcf_pkg::BUF_BYTES];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/dcf_collect.sv */
// Collector: phase machine, fill count, overflow flag and buffer writes.
`default_nettype none

module dcf_collect (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   input  wire logic                      drain_done,
   output dcf_pkg::wr_port_type           wr,
   output dcf_pkg::drain_ctl_type         drain,
   output logic [dcf_pkg::CNT_W-1:0]      fill_count,
   output logic                           overflow_seen,
   output dcf_pkg::phase_type             phase
);

   dcf_pkg::phase_type            phase_ff, phase_in;
   logic [dcf_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic                          ovf_ff, ovf_in;
   logic                          accept;
   logic                          room;

   assign req_stall = (phase_ff == dcf_pkg::PH_DRAIN);
   assign accept    = req_valid && !req_stall;
   assign room      = (fill_ff < dcf_pkg::CNT_W'(dcf_pkg::BUF_BYTES));

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dcf_pkg::PH_IDLE;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Next phase, counters and buffer write
   always_comb begin
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      wr.en        = 1'b0;
      wr.addr      = fill_ff[dcf_pkg::ADDR_W-1:0];
      wr.data      = req_in_byte;
      drain.start  = 1'b0;
      drain.length = fill_ff;
      unique case (phase_ff)
         dcf_pkg::PH_IDLE: begin
            if (accept && (req_in_byte == dcf_pkg::CH_QUERY ||
                           req_in_byte == dcf_pkg::CH_BANG)) begin
               wr.en    = 1'b1;
               wr.addr  = '0;
               fill_in  = dcf_pkg::CNT_W'(1);
               ovf_in   = 1'b0;
               phase_in = dcf_pkg::PH_COLLECT;
            end
         end
         dcf_pkg::PH_COLLECT: begin
            if (accept && req_in_byte != dcf_pkg::CH_NUL) begin
               if (room) begin
                  wr.en   = 1'b1;
                  fill_in = fill_ff + dcf_pkg::CNT_W'(1);
               end else begin
                  // full: drop, but a CR replaces the final byte
                  ovf_in = 1'b1;
                  if (req_in_byte == dcf_pkg::CH_CR) begin
                     wr.en   = 1'b1;
                     wr.addr = dcf_pkg::ADDR_W'(dcf_pkg::BUF_BYTES - 1);
                  end
               end
               if (req_in_byte == dcf_pkg::CH_CR) begin
                  phase_in = dcf_pkg::PH_EMIT;
               end
            end
         end
         dcf_pkg::PH_EMIT: begin
            // trigger byte is dropped unexamined
            if (accept) begin
               drain.start = 1'b1;
               phase_in    = dcf_pkg::PH_DRAIN;
            end
         end
         dcf_pkg::PH_DRAIN: begin
            if (drain_done) begin
               fill_in  = '0;
               ovf_in   = 1'b0;
               phase_in = dcf_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = dcf_pkg::PH_IDLE;
         end
      endcase
   end

   assign fill_count    = fill_ff;
   assign overflow_seen = ovf_ff;
   assign phase         = phase_ff;

endmodule

`default_nettype wire

/* hw/rtl/dcf_drain.sv */
// Drain engine: reads the frame from the buffer and drives the result register.
`default_nettype none

module dcf_drain (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dcf_pkg::drain_ctl_type     drain,
   output logic                            drain_done,
   output logic                            rd_en,
   output logic [dcf_pkg::ADDR_W-1:0]      rd_addr,
   input  wire logic [7:0]                 rd_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_frame
);

   logic                      active_ff, active_in;
   logic [dcf_pkg::CNT_W-1:0] ptr_ff, ptr_in;
   logic [dcf_pkg::CNT_W-1:0] len_ff;
   logic [dcf_pkg::CNT_W-1:0] ptr_next;
   logic                      data_valid_ff, data_valid_in;
   logic                      data_last_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff;
   logic                      out_last_ff;
   logic                      out_take;
   logic                      load_out;
   logic                      data_free;
   logic                      issue;

   // Handshake between read-data stage and result register
   assign ptr_next  = ptr_ff + dcf_pkg::CNT_W'(1);
   assign out_take  = out_valid_ff && !rsp_stall;
   assign load_out  = data_valid_ff && (!out_valid_ff || !rsp_stall);
   assign data_free = !data_valid_ff || load_out;
   assign issue     = active_ff && (ptr_ff != len_ff) && data_free;

   assign drain_done = out_take && out_last_ff;
   assign rd_en      = issue;
   assign rd_addr    = ptr_ff[dcf_pkg::ADDR_W-1:0];

   always_comb begin
      active_in     = active_ff;
      ptr_in        = ptr_ff;
      data_valid_in = data_valid_ff;
      out_valid_in  = out_valid_ff;
      if (drain.start) begin
         active_in = 1'b1;
         ptr_in    = '0;
      end else if (drain_done) begin
         active_in = 1'b0;
      end
      if (issue) begin
         ptr_in = ptr_next;
      end
      if (issue) begin
         data_valid_in = 1'b1;
      end else if (load_out) begin
         data_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         ptr_ff        <= '0;
         data_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         ptr_ff        <= ptr_in;
         data_valid_ff <= data_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (drain.start) begin
         len_ff <= drain.length;
      end
      if (issue) begin
         data_last_ff <= (ptr_next == len_ff);
      end
      if (load_out) begin
         out_byte_ff <= rd_data;
         out_last_ff <= data_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/delimited_command_framer.sv */
// Top level of the delimited command framer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  req     | in        | req_valid/req_stall  | req_in_byte[7:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_last_of_frame,
//          |           |                      | rsp_frame_length[6:0], rsp_overflowed
//
// Outside a drain one byte is accepted per cycle. In idle only a start character is
// stored; in a frame non-NUL bytes are stored until the buffer is full. The byte after
// a closing CR starts a drain, during which req_stall is high; the drain moves one
// frame byte per cycle through the buffer's single read port while rsp_stall is low.
// Reset is synchronous and clears all control state; buffer contents are not cleared.
`default_nettype none

module delimited_command_framer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_frame,
   output logic [6:0]      rsp_frame_length,
   output logic            rsp_overflowed
);

   dcf_pkg::wr_port_type          wr;
   dcf_pkg::drain_ctl_type        drain;
   dcf_pkg::phase_type            phase;
   logic                          drain_done;
   logic                          rd_en;
   logic [dcf_pkg::ADDR_W-1:0]    rd_addr;
   logic [7:0]                    rd_data;
   logic [dcf_pkg::CNT_W-1:0]     fill_count;
   logic                          overflow_seen;
   logic [dcf_pkg::CNT_W-1:0]     sent_ff;

   dcf_collect u_collect (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .drain_done    (drain_done),
      .wr            (wr),
      .drain         (drain),
      .fill_count    (fill_count),
      .overflow_seen (overflow_seen),
      .phase         (phase)
   );

   dcf_buffer u_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dcf_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .drain             (drain),
      .drain_done        (drain_done),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // Length and overflow hold steady for the whole drain
   assign rsp_frame_length = fill_count;
   assign rsp_overflowed   = overflow_seen;

   // Bytes delivered so far in the current frame
   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         sent_ff <= rsp_last_of_frame ? '0 : sent_ff + dcf_pkg::CNT_W'(1);
      end
   end

   // Results appear only while draining
   a_rsp_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> phase == dcf_pkg::PH_DRAIN)
      else $error("result valid outside drain phase");

   // The last byte closes a frame of exactly the reported length
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_frame)
         |-> (sent_ff + dcf_pkg::CNT_W'(1)) == rsp_frame_length)
      else $error("frame byte count differs from frame length");

   // Fill count never exceeds the buffer
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= dcf_pkg::CNT_W'(dcf_pkg::BUF_BYTES))
      else $error("fill count beyond buffer size");

   // Input reopens right after the final result transfer
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_frame) |=> !req_stall)
      else $error("input still stalled after frame end");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the delimited command framer.
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // One emitted frame byte with its side fields
   typedef struct packed {
      logic [7:0]                data;
      logic                      last;
      logic [dcf_pkg::CNT_W-1:0] length;
      logic                      ovf;
   } frame_byte_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic [7:0] req_in_byte       = 8'h00;
   logic       rsp_stall         = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_frame;
   logic [6:0] rsp_frame_length;
   logic       rsp_overflowed;

   // Shadow framer state
   dcf_pkg::phase_type        shadow_phase = dcf_pkg::PH_IDLE;
   logic [7:0]                shadow_buf [dcf_pkg::BUF_BYTES];
   logic [dcf_pkg::CNT_W-1:0] shadow_fill  = '0;
   logic                      shadow_ovf   = 1'b0;

   frame_byte_type expected_frame_bytes [$];
   int             mismatch_count = 0;
   int             send_gap_pct   = 0;
   int             stall_pct      = 0;

   delimited_command_framer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_overflowed    (rsp_overflowed)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Random backpressure on the result channel
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Advance the shadow framer by one accepted byte
   task automatic model_framer_byte(input logic [7:0] b);
      frame_byte_type rec;
      case (shadow_phase)
         dcf_pkg::PH_COLLECT: begin
            if (b != dcf_pkg::CH_NUL) begin
               if (shadow_fill < dcf_pkg::BUF_BYTES) begin
                  shadow_buf[shadow_fill] = b;
                  shadow_fill++;
               end else begin
                  // full: drop the byte, but a CR still lands in the last slot
                  shadow_ovf = 1'b1;
                  if (b == dcf_pkg::CH_CR) shadow_buf[dcf_pkg::BUF_BYTES-1] = b;
               end
               if (b == dcf_pkg::CH_CR) shadow_phase = dcf_pkg::PH_EMIT;
            end
         end
         dcf_pkg::PH_EMIT: begin
            // trigger byte itself is never looked at
            for (int i = 0; i < shadow_fill; i++) begin
               rec.data   = shadow_buf[i];
               rec.last   = (i + 1 == shadow_fill);
               rec.length = shadow_fill;
               rec.ovf    = shadow_ovf;
               expected_frame_bytes.push_back(rec);
            end
            shadow_phase = dcf_pkg::PH_IDLE;
            shadow_fill  = '0;
            shadow_ovf   = 1'b0;
         end
         default: begin
            shadow_phase = dcf_pkg::PH_IDLE;
            shadow_fill  = '0;
            if (b == dcf_pkg::CH_QUERY || b == dcf_pkg::CH_BANG) begin
               shadow_buf[0] = b;
               shadow_fill   = 1;
               shadow_ovf    = 1'b0;
               shadow_phase  = dcf_pkg::PH_COLLECT;
            end
         end
      endcase
   endtask

   // Offer one byte, with random idle cycles ahead of it, and wait for the transfer
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_framer_byte(b);
   endtask

   function automatic logic [7:0] rand_body_byte(input bit no_zero);
      int         r;
      logic [7:0] b;
      r = $urandom_range(99, 0);
      if (!no_zero && r < 12) return dcf_pkg::CH_NUL;
      if (r < 22) return ($urandom_range(1, 0) != 0) ? dcf_pkg::CH_QUERY : dcf_pkg::CH_BANG;
      do b = 8'($urandom_range(255, 1)); while (b == dcf_pkg::CH_CR);
      return b;
   endfunction

   // Start char, body, CR, then the byte that triggers the drain
   task automatic send_frame(input logic [7:0] start, input int nbody, input bit no_zero,
                             input logic [7:0] trigger);
      send_byte(start);
      for (int i = 0; i < nbody; i++) send_byte(rand_body_byte(no_zero));
      send_byte(dcf_pkg::CH_CR);
      send_byte(trigger);
   endtask

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frame_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h", rsp_out_byte));
         end else begin
            want = expected_frame_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte exp %02h got %02h",
                                         want.data, rsp_out_byte));
            if (rsp_last_of_frame !== want.last)
               report_mismatch($sformatf("last_of_frame exp %0b got %0b",
                                         want.last, rsp_last_of_frame));
            if (rsp_frame_length !== want.length)
               report_mismatch($sformatf("frame_length exp %0d got %0d",
                                         want.length, rsp_frame_length));
            if (rsp_overflowed !== want.ovf)
               report_mismatch($sformatf("overflowed exp %0b got %0b",
                                         want.ovf, rsp_overflowed));
         end
      end
   end

   // Idle noise, delimiters inside a frame, zero skipping, odd trigger bytes
   task automatic test_directed_frames();
      send_byte(dcf_pkg::CH_NUL);
      send_byte(8'hFF);
      send_byte(dcf_pkg::CH_CR);
      send_byte(8'h41);
      // ? A nul FF ! CR, trigger is a start char and must not open a frame
      send_byte(dcf_pkg::CH_QUERY);
      send_byte(8'h41);
      send_byte(dcf_pkg::CH_NUL);
      send_byte(8'hFF);
      send_byte(dcf_pkg::CH_BANG);
      send_byte(dcf_pkg::CH_CR);
      send_byte(dcf_pkg::CH_QUERY);
      // shortest frame, zero trigger
      send_byte(dcf_pkg::CH_BANG);
      send_byte(dcf_pkg::CH_CR);
      send_byte(dcf_pkg::CH_NUL);
      // zeros and a start char in the body
      send_byte(dcf_pkg::CH_QUERY);
      send_byte(dcf_pkg::CH_NUL);
      send_byte(dcf_pkg::CH_NUL);
      send_byte(dcf_pkg::CH_QUERY);
      send_byte(dcf_pkg::CH_CR);
      send_byte(dcf_pkg::CH_BANG);
      send_byte(8'h7F);
   endtask

   // Dropped bytes past a full buffer, then a CR on the full buffer
   task automatic test_buffer_limits();
      send_frame(dcf_pkg::CH_QUERY, dcf_pkg::BUF_BYTES + 1, 1'b1, 8'hFF);
   endtask

   // Mostly well-formed frames with random content, some loose noise in between
   task automatic test_random_frames(input int n_items);
      int         sent;
      int         nbody;
      logic [7:0] start;
      logic [7:0] trigger;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99, 0) < 15) begin
            send_byte(8'($urandom_range(255, 0)));
            sent++;
         end else begin
            start   = ($urandom_range(1, 0) != 0) ? dcf_pkg::CH_QUERY : dcf_pkg::CH_BANG;
            nbody   = $urandom_range(8, 0);
            trigger = ($urandom_range(3, 0) == 0) ? start : 8'($urandom_range(255, 0));
            send_frame(start, nbody, 1'b0, trigger);
            sent += nbody + 3;
         end
      end
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 35;
      stall_pct    = 62;
      test_directed_frames();
      test_buffer_limits();
      test_random_frames(5);

      send_gap_pct = 62;
      stall_pct    = 35;
      test_random_frames(5);

      send_gap_pct = 0;
      stall_pct    = 0;
      test_random_frames(5);
      // close any frame that noise left open
      send_frame(dcf_pkg::CH_QUERY, 2, 1'b1, 8'h00);
      req_valid <= 1'b0;

      // let the last drain finish, then watch for stray results
      waited = 0;
      while (expected_frame_bytes.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_frame_bytes.size() != 0)
         report_mismatch($sformatf("%0d frame bytes never arrived",
                                   expected_frame_bytes.size()));
      repeat (dcf_pkg::BUF_BYTES + 8) @(posedge clock);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
